FILE: hdl/wfc_pkg.sv
`timescale 1ns / 1ps
// Package for the wrapping framebuffer compositor.
// Holds command codes, register indexes, fixed widths and shared types.
package wfc_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_RADIUS = 63;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 12;
  localparam int OFF_W   = 9;
  localparam int CH_W    = 8;
  localparam int RAD_W   = 6;
  localparam int CFG_DW  = 10;
  localparam int CFG_IW  = 1;
  localparam int MOD_W   = 13;

  localparam logic [CMD_W-1:0] CMD_ADD_SAT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALPHA_ADD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALPHA_OVR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [9:0]  LUM_LIMIT  = 10'd30;
  localparam logic [16:0] DIV255_MUL = 17'h08081;
  localparam int          DIV255_SH  = 23;

  typedef struct packed {
    logic                    start;
    logic signed [MOD_W-1:0] operand;
    logic [MOD_W-1:0]        modulus;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] result;
  } mod_rsp_t;

endpackage

FILE: hdl/wfc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items and result items.
// Depends on wfc_pkg for field widths.
interface wfc_in_if;
  logic                                valid;
  logic                                ready;
  logic [wfc_pkg::CMD_W-1:0]           cmd;
  logic signed [wfc_pkg::POS_W-1:0]    pos_x;
  logic signed [wfc_pkg::POS_W-1:0]    pos_y;
  logic signed [wfc_pkg::OFF_W-1:0]    off_x;
  logic signed [wfc_pkg::OFF_W-1:0]    off_y;
  logic [wfc_pkg::CH_W-1:0]            red;
  logic [wfc_pkg::CH_W-1:0]            green;
  logic [wfc_pkg::CH_W-1:0]            blue;
  logic [wfc_pkg::CH_W-1:0]            alpha;
  logic [wfc_pkg::RAD_W-1:0]           radius;
  modport source (output valid, cmd, pos_x, pos_y, off_x, off_y, red, green, blue, alpha,
                  radius, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, off_x, off_y, red, green, blue, alpha,
                radius, output ready);
endinterface

interface wfc_out_if;
  logic                     valid;
  logic                     ready;
  logic [wfc_pkg::CH_W-1:0] pixel_red;
  logic [wfc_pkg::CH_W-1:0] pixel_green;
  logic [wfc_pkg::CH_W-1:0] pixel_blue;
  logic                     region_empty;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, region_empty,
                  input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, region_empty,
                output ready);
endinterface

FILE: hdl/wfc_mod_unit.sv
`timescale 1ns / 1ps
// Iterative signed modulo unit, one quotient bit per cycle, result in 0..n-1.
// Depends on wfc_pkg for request and response types.
module wfc_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  wfc_pkg::mod_req_t req,
  output wfc_pkg::mod_rsp_t rsp
);
  localparam int MW = wfc_pkg::MOD_W;
  localparam int CW = $clog2(MW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] mag_r, mag_nxt;
  logic [MW-1:0] n_r, n_nxt;
  logic          neg_r, neg_nxt;
  logic [MW:0]   rem_r, rem_nxt;
  logic [MW:0]   trial;

  assign trial = {rem_r[MW-1:0], mag_r[cnt_r]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    n_nxt    = n_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.operand[MW-1];
      mag_nxt  = req.operand[MW-1] ? MW'(-req.operand) : MW'(req.operand);
      n_nxt    = req.modulus;
      cnt_nxt  = CW'(MW - 1);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, n_r}) ? trial - {1'b0, n_r} : trial;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    n_r   <= n_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (neg_r && rem_r != '0) ? n_r - rem_r[MW-1:0] : rem_r[MW-1:0];

endmodule

FILE: hdl/wfc_frame_ram.sv
`timescale 1ns / 1ps
// Single-write, single-read frame memory of RGB888 pixels with registered read data.
// Depends on no other file.
module wfc_frame_ram #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata_r
);
  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: hdl/wrapping_framebuffer_compositor.sv
`timescale 1ns / 1ps
// Wrapping framebuffer compositor: top level with sequencer, blend path and query walk.
// A write runs two modulo operations, address, read, blend steps B1 to B3 for each of
// three channels and write; a read or skipped blend ends at the read; a query walks rings.
// One transaction is in flight at a time; input is ready again once the result is taken.
// After reset the memory is cleared, one pixel per cycle, all MAX_WIDTH*MAX_HEIGHT of them,
// and no input is taken until the pass ends. Size registers reset to their maxima.
module wrapping_framebuffer_compositor #(
  parameter int MAX_WIDTH  = wfc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wfc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = wfc_pkg::DEF_MAX_RADIUS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wfc_in_if.sink                     in_ch,
  wfc_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [wfc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wfc_pkg::CFG_DW-1:0] cfg_wr_data
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int PW    = YW + WW;
  localparam int DW    = $clog2(MAX_RADIUS + 1);
  localparam int MW    = wfc_pkg::MOD_W;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_ADDR  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_RDW   = 4'd5;
  localparam logic [3:0] S_B1    = 4'd6;
  localparam logic [3:0] S_B2    = 4'd7;
  localparam logic [3:0] S_B3    = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_QSTEP = 4'd10;
  localparam logic [3:0] S_QADDR = 4'd11;
  localparam logic [3:0] S_QRD   = 4'd12;
  localparam logic [3:0] S_QCHK  = 4'd13;

  logic [3:0]    state_r, state_nxt;
  logic [AW:0]   clr_r, clr_nxt;
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;

  logic [wfc_pkg::CMD_W-1:0]        cmd_r;
  logic signed [wfc_pkg::POS_W-1:0] px_r, py_r;
  logic signed [wfc_pkg::OFF_W-1:0] ox_r, oy_r;
  logic [2:0][7:0] src_r;
  logic [7:0]      a_r;
  logic [DW-1:0]   rad_r;

  logic [1:0]    midx_r, midx_nxt;
  logic          mgo_r, mgo_nxt;
  logic [XW-1:0] tx_r, cx_r, xp_r, xm_r;
  logic [YW-1:0] ty_r, cy_r, yp_r, ym_r;
  logic [AW-1:0] addr_r;
  logic [2:0][7:0] pix_r;
  logic [1:0]    k_r, k_nxt;
  logic [15:0]   t_r;
  logic [7:0]    q_r;
  logic [DW-1:0] d_r;
  logic [2:0]    pt_r, pt_nxt;

  logic          out_valid_r;
  logic [2:0][7:0] out_pix_r;
  logic          out_empty_r;

  wfc_pkg::mod_req_t mreq;
  wfc_pkg::mod_rsp_t mrsp;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata, ram_rdata;

  logic is_query, is_write, accept, finish, fin_empty;
  logic [XW-1:0] qx;
  logic [YW-1:0] qy;
  logic [PW-1:0] prod;
  logic [9:0]    lum;
  logic [8:0]    sum9;
  logic [32:0]   qprod;
  logic [7:0]    oldc, srcc;

  assign is_query = (cmd_r == wfc_pkg::CMD_QUERY);
  assign is_write = (cmd_r == wfc_pkg::CMD_ADD_SAT) ||
                    ((cmd_r == wfc_pkg::CMD_ALPHA_ADD || cmd_r == wfc_pkg::CMD_ALPHA_OVR) &&
                     a_r != 8'd0);
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    mreq.start   = (state_r == S_MOD) && !mgo_r;
    mreq.modulus = midx_r[0] ? MW'(h_r) : MW'(w_r);
    case (midx_r)
      2'd0:    mreq.operand = MW'(px_r) + MW'(ox_r);
      2'd1:    mreq.operand = MW'(py_r) + MW'(oy_r);
      2'd2:    mreq.operand = MW'(px_r);
      default: mreq.operand = MW'(py_r);
    endcase
  end

  wfc_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  always_comb begin
    case (pt_r)
      3'd0:    begin qx = xp_r; qy = cy_r; end
      3'd1:    begin qx = xm_r; qy = cy_r; end
      3'd2:    begin qx = cx_r; qy = yp_r; end
      3'd3:    begin qx = cx_r; qy = ym_r; end
      3'd4:    begin qx = xp_r; qy = yp_r; end
      3'd5:    begin qx = xm_r; qy = ym_r; end
      3'd6:    begin qx = xp_r; qy = ym_r; end
      default: begin qx = xm_r; qy = yp_r; end
    endcase
    if (state_r == S_ADDR) begin
      prod = PW'(ty_r) * PW'(w_r) + PW'(tx_r);
    end else begin
      prod = PW'(qy) * PW'(w_r) + PW'(qx);
    end
  end

  assign lum   = 10'(ram_rdata[7:0]) + 10'(ram_rdata[15:8]) + 10'(ram_rdata[23:16]);
  assign oldc  = pix_r[k_r];
  assign srcc  = src_r[k_r];
  assign qprod = 33'(t_r) * 33'(wfc_pkg::DIV255_MUL);
  always_comb begin
    case (cmd_r)
      wfc_pkg::CMD_ADD_SAT:   sum9 = 9'(oldc) + 9'(srcc);
      wfc_pkg::CMD_ALPHA_ADD: sum9 = 9'(oldc) + 9'(q_r);
      default:                sum9 = 9'(q_r);
    endcase
  end

  assign ram_we    = (state_r == S_CLR) || (state_r == S_WR);
  assign ram_waddr = (state_r == S_CLR) ? clr_r[AW-1:0] : addr_r;
  assign ram_wdata = (state_r == S_CLR) ? 24'd0 : {pix_r[2], pix_r[1], pix_r[0]};
  assign ram_re    = (state_r == S_RD) || (state_r == S_QRD);

  wfc_frame_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(addr_r), .rdata_r(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    midx_nxt  = midx_r;
    mgo_nxt   = mgo_r;
    k_nxt     = k_r;
    pt_nxt    = pt_r;
    finish    = 1'b0;
    fin_empty = 1'b0;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MOD;
          midx_nxt  = 2'd0;
          mgo_nxt   = 1'b0;
        end
      end
      S_MOD: begin
        if (!mgo_r) begin
          mgo_nxt = 1'b1;
        end else if (mrsp.done) begin
          mgo_nxt  = 1'b0;
          midx_nxt = midx_r + 1'b1;
          if (midx_r == 2'd3 || (midx_r == 2'd1 && !is_query)) begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_ADDR: state_nxt = S_RD;
      S_RD:   state_nxt = S_RDW;
      S_RDW: begin
        k_nxt = 2'd0;
        if (is_write) begin
          state_nxt = S_B1;
        end else if (is_query && rad_r != '0) begin
          state_nxt = S_QSTEP;
        end else begin
          finish    = 1'b1;
          fin_empty = is_query;
          state_nxt = S_IDLE;
        end
      end
      S_B1: state_nxt = S_B2;
      S_B2: state_nxt = S_B3;
      S_B3: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 2'd2) ? S_WR : S_B1;
      end
      S_WR: begin
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QSTEP: begin
        pt_nxt    = 3'd0;
        state_nxt = S_QADDR;
      end
      S_QADDR: state_nxt = S_QRD;
      S_QRD:   state_nxt = S_QCHK;
      S_QCHK: begin
        if (lum > wfc_pkg::LUM_LIMIT) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else if (pt_r == 3'd7) begin
          if (d_r == rad_r) begin
            finish    = 1'b1;
            fin_empty = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_QSTEP;
          end
        end else begin
          pt_nxt    = pt_r + 1'b1;
          state_nxt = S_QADDR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      midx_r      <= '0;
      mgo_r       <= 1'b0;
      k_r         <= '0;
      pt_r        <= '0;
      out_valid_r <= 1'b0;
      w_r         <= WW'(MAX_WIDTH);
      h_r         <= HW'(MAX_HEIGHT);
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      midx_r  <= midx_nxt;
      mgo_r   <= mgo_nxt;
      k_r     <= k_nxt;
      pt_r    <= pt_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        if (cfg_index == wfc_pkg::REG_FRAME_WIDTH) begin
          w_r <= (cfg_wr_data == '0) ? WW'(1) :
                 (32'(cfg_wr_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_wr_data);
        end else begin
          h_r <= (cfg_wr_data == '0) ? HW'(1) :
                 (32'(cfg_wr_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_wr_data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      px_r  <= in_ch.pos_x;
      py_r  <= in_ch.pos_y;
      ox_r  <= in_ch.off_x;
      oy_r  <= in_ch.off_y;
      src_r <= {in_ch.blue, in_ch.green, in_ch.red};
      a_r   <= in_ch.alpha;
      rad_r <= (32'(in_ch.radius) > MAX_RADIUS) ? DW'(MAX_RADIUS) : DW'(in_ch.radius);
    end
    if (state_r == S_MOD && mgo_r && mrsp.done) begin
      case (midx_r)
        2'd0:    tx_r <= XW'(mrsp.result);
        2'd1:    ty_r <= YW'(mrsp.result);
        2'd2:    cx_r <= XW'(mrsp.result);
        default: cy_r <= YW'(mrsp.result);
      endcase
    end
    if (state_r == S_ADDR || state_r == S_QADDR) begin
      addr_r <= AW'(prod);
    end
    if (state_r == S_RDW) begin
      pix_r <= {ram_rdata[23:16], ram_rdata[15:8], ram_rdata[7:0]};
      xp_r  <= cx_r;
      xm_r  <= cx_r;
      yp_r  <= cy_r;
      ym_r  <= cy_r;
      d_r   <= '0;
    end
    if (state_r == S_B1) begin
      t_r <= (cmd_r == wfc_pkg::CMD_ALPHA_OVR) ?
             16'(srcc) * 16'(a_r) + 16'(oldc) * 16'(8'd255 - a_r) :
             16'(srcc) * 16'(a_r);
    end
    if (state_r == S_B2) begin
      q_r <= 8'(qprod >> wfc_pkg::DIV255_SH);
    end
    if (state_r == S_B3) begin
      pix_r[k_r] <= sum9[8] ? 8'd255 : sum9[7:0];
    end
    if (state_r == S_QSTEP) begin
      d_r  <= d_r + 1'b1;
      xp_r <= (32'(xp_r) == 32'(w_r) - 1) ? '0 : xp_r + 1'b1;
      xm_r <= (xm_r == '0) ? XW'(w_r - 1'b1) : xm_r - 1'b1;
      yp_r <= (32'(yp_r) == 32'(h_r) - 1) ? '0 : yp_r + 1'b1;
      ym_r <= (ym_r == '0) ? YW'(h_r - 1'b1) : ym_r - 1'b1;
    end
    if (finish) begin
      out_pix_r   <= (state_r == S_RDW) ?
                     {ram_rdata[23:16], ram_rdata[15:8], ram_rdata[7:0]} : pix_r;
      out_empty_r <= fin_empty;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_red    = out_pix_r[0];
  assign out_ch.pixel_green  = out_pix_r[1];
  assign out_ch.pixel_blue   = out_pix_r[2];
  assign out_ch.region_empty = out_empty_r;

  a_accept_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MOD)
    else $error("accepted transaction did not start the modulo sequence");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> state_r == S_MOD && mgo_r)
    else $error("modulo result arrived outside the modulo sequence");

  a_empty_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    finish && !is_query |=> out_ch.valid && !out_ch.region_empty)
    else $error("region_empty set for a non-query transaction");

endmodule
